[rtl/mlbc_pkg.sv]
// Shared types and constants for the multi-LED blink controller.
// Used by the interfaces, the LED lane, the result stage and the top level.
`timescale 1ns / 1ps

package mlbc_pkg;

	localparam int LED_COUNT = 5;
	localparam int FIELD_W   = 5;
	localparam int OP_W      = 2;
	localparam int MODE_W    = 2;
	localparam int TIME_W    = 32;
	localparam int NTT_W     = 64;

	localparam logic [TIME_W-1:0]  DEFAULT_PERIOD_MS = 32'd500;
	localparam logic [FIELD_W-1:0] MASK_RESET        = 5'd31;

	typedef enum logic [OP_W-1:0] {
		OP_TICK   = 2'd0,
		OP_MODE   = 2'd1,
		OP_PERIOD = 2'd2
	} op_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_ON    = 2'd0,
		MODE_OFF   = 2'd1,
		MODE_BLINK = 2'd2
	} mode_t;

	typedef struct packed {
		logic              tick;
		logic              mode_sel;
		logic              period_sel;
		logic              blink;
		logic              turn_on;
		logic [TIME_W-1:0] period;
		logic [TIME_W-1:0] now;
	} lane_ctl_t;

endpackage

[rtl/mlbc_if.sv]
// Channel interfaces of the blink controller: command items, results and
// the polarity register write port. Depends on mlbc_pkg.
`timescale 1ns / 1ps

interface mlbc_cmd_if;
	logic                           valid;
	logic                           ready;
	logic [mlbc_pkg::OP_W-1:0]      op;
	logic [mlbc_pkg::FIELD_W-1:0]   led_index;
	logic [mlbc_pkg::MODE_W-1:0]    mode_command;
	logic [mlbc_pkg::TIME_W-1:0]    period_ms;
	logic [mlbc_pkg::TIME_W-1:0]    now_ms;

	modport source (output valid, op, led_index, mode_command, period_ms, now_ms,
		input ready);
	modport sink (input valid, op, led_index, mode_command, period_ms, now_ms,
		output ready);
endinterface

interface mlbc_res_if;
	logic                         valid;
	logic                         ready;
	logic [mlbc_pkg::FIELD_W-1:0] pin_levels;
	logic [mlbc_pkg::FIELD_W-1:0] lit_mask;

	modport source (output valid, pin_levels, lit_mask, input ready);
	modport sink (input valid, pin_levels, lit_mask, output ready);
endinterface

interface mlbc_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [mlbc_pkg::FIELD_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

[rtl/mlbc_lane.sv]
// State and update logic of one LED: mode, lit bit, period and next-toggle time.
// Depends on mlbc_pkg for the lane control struct and widths.
`timescale 1ns / 1ps

module mlbc_lane (
	input  logic                clk,
	input  logic                arst_n,
	input  mlbc_pkg::lane_ctl_t ctl,
	output logic                lit,
	output logic                lit_next
);

	logic                          blink_q, blink_d;
	logic                          lit_q, lit_d;
	logic [mlbc_pkg::TIME_W-1:0]   period_q, period_d;
	logic [mlbc_pkg::NTT_W-1:0]    ntt_q, ntt_d;
	logic                          due;

	assign due = blink_q &&
		(ntt_q <= {{(mlbc_pkg::NTT_W - mlbc_pkg::TIME_W){1'b0}}, ctl.now});

	always_comb begin
		blink_d  = blink_q;
		lit_d    = lit_q;
		period_d = period_q;
		ntt_d    = ntt_q;
		if (ctl.tick && due) begin
			lit_d = ~lit_q;
			ntt_d = ntt_q + {{(mlbc_pkg::NTT_W - mlbc_pkg::TIME_W){1'b0}}, period_q};
		end
		if (ctl.mode_sel) begin
			if (ctl.blink) begin
				blink_d = 1'b1;
			end else begin
				blink_d = 1'b0;
				lit_d   = ctl.turn_on;
			end
		end
		if (ctl.period_sel) begin
			period_d = ctl.period;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blink_q  <= 1'b0;
			lit_q    <= 1'b0;
			period_q <= mlbc_pkg::DEFAULT_PERIOD_MS;
			ntt_q    <= '0;
		end else begin
			blink_q  <= blink_d;
			lit_q    <= lit_d;
			period_q <= period_d;
			ntt_q    <= ntt_d;
		end
	end

	assign lit      = lit_q;
	assign lit_next = lit_d;

endmodule

[rtl/mlbc_out_stage.sv]
// Result register: holds one result beat and applies the pin polarity.
// Depends on mlbc_pkg and the mlbc_res_if interface.
`timescale 1ns / 1ps

module mlbc_out_stage (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           load,
	input  logic [mlbc_pkg::FIELD_W-1:0]   lit_bits,
	input  logic [mlbc_pkg::FIELD_W-1:0]   active_low_mask,
	output logic                           free,
	mlbc_res_if.source                     res
);

	logic                         valid_q;
	logic [mlbc_pkg::FIELD_W-1:0] pin_q;
	logic [mlbc_pkg::FIELD_W-1:0] lit_q;

	assign free = !valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (res.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pin_q <= lit_bits ^ active_low_mask;
			lit_q <= lit_bits;
		end
	end

	assign res.valid      = valid_q;
	assign res.pin_levels = pin_q;
	assign res.lit_mask   = lit_q;

endmodule

[rtl/multi_led_blink_controller.sv]
// Top level of the multi-LED blink controller: input register, LED lanes,
// polarity register and result stage. Depends on mlbc_pkg, the mlbc
// interfaces, mlbc_lane and mlbc_out_stage.
//
// Usage: command items arrive on the cmd channel (time tick, set mode or set
// period) and each accepted beat yields exactly one result beat on the res
// channel with the pin levels and the lit mask after that item's update.
// The cfg channel writes the active-low polarity mask; it is always ready and
// should be written only while no item is in flight.
// A cmd beat passes through the input register, where all LED lanes compare
// and add in parallel, and then through the result register to the res beat.
// Throughput is one item per cycle while the receiver does not stall, set by
// the single state update per cycle in the lanes.
// After reset every LED is static and off, periods are 500 ms, next-toggle
// times are zero and the polarity mask is all ones.
// When the receiver stalls, the result register holds its beat and the input
// register can still take one more item; after that cmd.ready drops until
// the result is taken.
`timescale 1ns / 1ps

module multi_led_blink_controller (
	input  logic      clk,
	input  logic      arst_n,
	mlbc_cmd_if.sink  cmd,
	mlbc_res_if.source res,
	mlbc_cfg_if.sink  cfg
);

	logic                            valid_s1;
	logic [mlbc_pkg::OP_W-1:0]       op_s1;
	logic [mlbc_pkg::FIELD_W-1:0]    idx_s1;
	logic [mlbc_pkg::MODE_W-1:0]     mode_s1;
	logic [mlbc_pkg::TIME_W-1:0]     period_s1;
	logic [mlbc_pkg::TIME_W-1:0]     now_s1;
	logic [mlbc_pkg::FIELD_W-1:0]    mask_q;
	logic                            out_free;
	logic                            advance;
	logic [mlbc_pkg::LED_COUNT-1:0]  lit_cur;
	logic [mlbc_pkg::LED_COUNT-1:0]  lit_next;
	logic [mlbc_pkg::FIELD_W-1:0]    lit_field;
	mlbc_pkg::lane_ctl_t             ctl [mlbc_pkg::LED_COUNT];

	assign advance   = valid_s1 && out_free;
	assign cmd.ready = !valid_s1 || out_free;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			op_s1     <= cmd.op;
			idx_s1    <= cmd.led_index;
			mode_s1   <= cmd.mode_command;
			period_s1 <= cmd.period_ms;
			now_s1    <= cmd.now_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= mlbc_pkg::MASK_RESET;
		end else if (cfg.valid && cfg.ready) begin
			mask_q <= cfg.data;
		end
	end

	for (genvar i = 0; i < mlbc_pkg::LED_COUNT; i++) begin : g_lane
		always_comb begin
			ctl[i].tick       = advance && (op_s1 == mlbc_pkg::OP_TICK);
			ctl[i].mode_sel   = advance && (op_s1 == mlbc_pkg::OP_MODE) &&
				(idx_s1 == mlbc_pkg::FIELD_W'(i));
			ctl[i].period_sel = advance && (op_s1 == mlbc_pkg::OP_PERIOD) &&
				(idx_s1 == mlbc_pkg::FIELD_W'(i));
			ctl[i].blink      = (mode_s1 == mlbc_pkg::MODE_BLINK);
			ctl[i].turn_on    = (mode_s1 == mlbc_pkg::MODE_ON);
			ctl[i].period     = period_s1;
			ctl[i].now        = now_s1;
		end

		mlbc_lane u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl[i]),
			.lit      (lit_cur[i]),
			.lit_next (lit_next[i])
		);
	end

	for (genvar i = 0; i < mlbc_pkg::FIELD_W; i++) begin : g_field
		if (i < mlbc_pkg::LED_COUNT) begin : g_led
			assign lit_field[i] = lit_next[i];
		end else begin : g_none
			assign lit_field[i] = 1'b0;
		end
	end

	mlbc_out_stage u_out (
		.clk             (clk),
		.arst_n          (arst_n),
		.load            (advance),
		.lit_bits        (lit_field),
		.active_low_mask (mask_q),
		.free            (out_free),
		.res             (res)
	);

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> cmd.ready)
		else $error("Command channel stalled with an empty input register.");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> res.valid)
		else $error("Processed item produced no result beat.");

	a_static_on: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (op_s1 == mlbc_pkg::OP_MODE) && (mode_s1 == mlbc_pkg::MODE_ON) &&
		(idx_s1 == '0)) |=> lit_cur[0])
		else $error("Static on command did not light the first LED.");

endmodule

[tb/sv/multi_led_blink_controller_test.sv]
// Self-checking testbench for the multi-LED blink controller.
// Drives command beats and polarity writes and checks every result beat
// against a cycle-free predictor; depends on mlbc_pkg and the mlbc interfaces.
`timescale 1ns / 1ps

module multi_led_blink_controller_test;

	import mlbc_pkg::*;

	localparam logic [OP_W-1:0]   OP_UNUSED   = 2'd3;
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam int                PHASE_ITEMS = 290;

	typedef struct {
		logic [OP_W-1:0]    op;
		logic [FIELD_W-1:0] led_index;
		logic [MODE_W-1:0]  mode_command;
		logic [TIME_W-1:0]  period_ms;
		logic [TIME_W-1:0]  now_ms;
	} cmd_item_t;

	typedef struct packed {
		logic [FIELD_W-1:0] pin_levels;
		logic [FIELD_W-1:0] lit_mask;
	} levels_t;

	logic clk = 1'b0;
	logic arst_n;

	mlbc_cmd_if cmd_ch ();
	mlbc_res_if res_ch ();
	mlbc_cfg_if cfg_ch ();

	multi_led_blink_controller u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	always #1 clk = ~clk;

	logic               led_blink  [LED_COUNT];
	logic               led_lit    [LED_COUNT];
	logic [TIME_W-1:0]  led_period [LED_COUNT];
	logic [NTT_W-1:0]   led_next   [LED_COUNT];
	logic [FIELD_W-1:0] polarity_mask;

	cmd_item_t   pending_cmds [$];
	levels_t     expected_levels [$];
	cmd_item_t   next_cmd;
	logic [TIME_W-1:0] clock_ms;

	int unsigned cmds_pushed;
	int unsigned cmds_accepted;
	int unsigned results_seen;
	int unsigned toggle_count;
	int unsigned polarity_writes;
	int unsigned mismatch_count;
	int unsigned gap_left;
	int unsigned stall_left;
	bit          quiet_phase;

	task automatic report_mismatch(input string what, input logic [FIELD_W-1:0] got,
		input logic [FIELD_W-1:0] want);
		mismatch_count++;
		if (mismatch_count <= 40)
			$display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
	endtask

	task automatic predict_levels(input logic [OP_W-1:0] op, input logic [FIELD_W-1:0] idx,
		input logic [MODE_W-1:0] mode, input logic [TIME_W-1:0] period,
		input logic [TIME_W-1:0] now);
		levels_t e;
		if (op == OP_TICK) begin
			for (int i = 0; i < LED_COUNT; i++) begin
				if (led_blink[i] && led_next[i] <= {32'd0, now}) begin
					led_lit[i] = ~led_lit[i];
					led_next[i] = led_next[i] + {32'd0, led_period[i]};
					toggle_count++;
				end
			end
		end else if (op == OP_MODE) begin
			if (idx < LED_COUNT) begin
				if (mode == MODE_BLINK) begin
					led_blink[idx] = 1'b1;
				end else begin
					led_blink[idx] = 1'b0;
					led_lit[idx] = (mode == MODE_ON);
				end
			end
		end else if (op == OP_PERIOD) begin
			if (idx < LED_COUNT)
				led_period[idx] = period;
		end
		for (int i = 0; i < FIELD_W; i++)
			e.lit_mask[i] = (i < LED_COUNT) ? led_lit[i] : 1'b0;
		e.pin_levels = e.lit_mask ^ polarity_mask;
		expected_levels.push_back(e);
	endtask

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(6, 20);
	endfunction

	function automatic int unsigned pick_stall();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(6, 25);
	endfunction

	function automatic logic [FIELD_W-1:0] pick_led();
		if ($urandom_range(0, 99) < 85)
			return FIELD_W'($urandom_range(0, LED_COUNT - 1));
		return FIELD_W'($urandom_range(0, 31));
	endfunction

	function automatic cmd_item_t random_cmd();
		cmd_item_t it;
		int unsigned r;
		int unsigned s;
		it.op = OP_UNUSED;
		it.led_index = FIELD_W'($urandom);
		it.mode_command = MODE_W'($urandom);
		it.period_ms = $urandom;
		it.now_ms = $urandom;
		r = $urandom_range(0, 99);
		s = $urandom_range(0, 99);
		if (r < 50) begin
			it.op = OP_TICK;
			if (s < 88) begin
				clock_ms = clock_ms + $urandom_range(0, 40);
				it.now_ms = clock_ms;
			end else if (s < 94) begin
				it.now_ms = clock_ms - $urandom_range(0, 100);
			end
		end else if (r < 72) begin
			it.op = OP_MODE;
			it.led_index = pick_led();
			if (s < 50)
				it.mode_command = MODE_BLINK;
		end else if (r < 93) begin
			it.op = OP_PERIOD;
			it.led_index = pick_led();
			if (s < 10)
				it.period_ms = '0;
			else if (s < 94)
				it.period_ms = $urandom_range(1, 60);
		end
		return it;
	endfunction

	task automatic push_cmd(input logic [OP_W-1:0] op, input logic [FIELD_W-1:0] idx,
		input logic [MODE_W-1:0] mode, input logic [TIME_W-1:0] period,
		input logic [TIME_W-1:0] now);
		cmd_item_t it;
		it.op = op;
		it.led_index = idx;
		it.mode_command = mode;
		it.period_ms = period;
		it.now_ms = now;
		pending_cmds.push_back(it);
		cmds_pushed++;
	endtask

	task automatic push_random(input int unsigned count);
		for (int unsigned n = 0; n < count; n++) begin
			pending_cmds.push_back(random_cmd());
			cmds_pushed++;
		end
	endtask

	task automatic wait_drained();
		do @(posedge clk);
		while (cmds_accepted != cmds_pushed || expected_levels.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_polarity(input logic [FIELD_W-1:0] value);
		cfg_ch.data <= value;
		cfg_ch.valid <= 1'b1;
		do @(posedge clk);
		while (!cfg_ch.ready);
		polarity_mask = value;
		polarity_writes++;
		cfg_ch.valid <= 1'b0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
			gap_left = 0;
		end else begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				predict_levels(cmd_ch.op, cmd_ch.led_index, cmd_ch.mode_command,
					cmd_ch.period_ms, cmd_ch.now_ms);
				cmds_accepted++;
			end
			if (!cmd_ch.valid || cmd_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					cmd_ch.valid <= 1'b0;
				end else if (pending_cmds.size() > 0) begin
					next_cmd = pending_cmds.pop_front();
					cmd_ch.op <= next_cmd.op;
					cmd_ch.led_index <= next_cmd.led_index;
					cmd_ch.mode_command <= next_cmd.mode_command;
					cmd_ch.period_ms <= next_cmd.period_ms;
					cmd_ch.now_ms <= next_cmd.now_ms;
					cmd_ch.valid <= 1'b1;
					gap_left = quiet_phase ? 0 : pick_gap();
				end else begin
					cmd_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		levels_t e;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				results_seen++;
				if (expected_levels.size() == 0) begin
					report_mismatch("unexpected result beat, lit_mask", res_ch.lit_mask, '0);
				end else begin
					e = expected_levels.pop_front();
					if (res_ch.pin_levels !== e.pin_levels)
						report_mismatch("pin_levels", res_ch.pin_levels, e.pin_levels);
					if (res_ch.lit_mask !== e.lit_mask)
						report_mismatch("lit_mask", res_ch.lit_mask, e.lit_mask);
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
				stall_left = quiet_phase ? 0 : pick_stall();
			end
		end
	end

	initial begin
		#1_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		int unsigned waited;
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.op = OP_TICK;
		cmd_ch.led_index = '0;
		cmd_ch.mode_command = MODE_ON;
		cmd_ch.period_ms = '0;
		cmd_ch.now_ms = '0;
		res_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		polarity_mask = MASK_RESET;
		clock_ms = '0;
		quiet_phase = 1'b0;
		for (int i = 0; i < LED_COUNT; i++) begin
			led_blink[i] = 1'b0;
			led_lit[i] = 1'b0;
			led_period[i] = DEFAULT_PERIOD_MS;
			led_next[i] = '0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_polarity(5'd0);
		push_cmd(OP_TICK, FIELD_W'($urandom), MODE_W'($urandom), $urandom, 32'd0);
		push_cmd(OP_MODE, 5'd0, MODE_ON, $urandom, $urandom);
		push_cmd(OP_MODE, 5'd1, MODE_OFF, $urandom, $urandom);
		push_cmd(OP_MODE, 5'd2, MODE_BLINK, $urandom, $urandom);
		push_cmd(OP_MODE, 5'd3, MODE_UNUSED, $urandom, $urandom);
		push_cmd(OP_MODE, 5'd4, MODE_ON, $urandom, $urandom);
		push_cmd(OP_MODE, 5'd4, MODE_BLINK, $urandom, $urandom);
		push_cmd(OP_MODE, 5'd5, MODE_ON, $urandom, $urandom);
		push_cmd(OP_MODE, 5'd31, MODE_ON, $urandom, $urandom);
		push_cmd(OP_PERIOD, 5'd2, MODE_W'($urandom), 32'd0, $urandom);
		push_cmd(OP_PERIOD, 5'd31, MODE_W'($urandom), 32'd7, $urandom);
		push_cmd(OP_PERIOD, 5'd3, MODE_W'($urandom), 32'hFFFF_FFFF, $urandom);
		push_cmd(OP_PERIOD, 5'd3, MODE_W'($urandom), 32'd500, $urandom);
		push_cmd(OP_TICK, FIELD_W'($urandom), MODE_W'($urandom), $urandom, 32'd0);
		push_cmd(OP_TICK, FIELD_W'($urandom), MODE_W'($urandom), $urandom, 32'd0);
		push_cmd(OP_TICK, FIELD_W'($urandom), MODE_W'($urandom), $urandom, 32'hFFFF_FFFF);
		push_cmd(OP_UNUSED, 5'd31, MODE_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_cmd(OP_PERIOD, 5'd1, MODE_W'($urandom), 32'd3, $urandom);
		push_cmd(OP_MODE, 5'd1, MODE_BLINK, $urandom, $urandom);
		repeat (5)
			push_cmd(OP_TICK, FIELD_W'($urandom), MODE_W'($urandom), $urandom, 32'd10);
		clock_ms = 32'd2000;

		push_random(PHASE_ITEMS / 2);
		wait_drained();
		push_random(PHASE_ITEMS - PHASE_ITEMS / 2);
		wait_drained();

		write_polarity(5'd31);
		quiet_phase = 1'b1;
		push_random(PHASE_ITEMS);
		wait_drained();
		quiet_phase = 1'b0;

		write_polarity(FIELD_W'($urandom));
		push_random(PHASE_ITEMS);
		wait_drained();

		write_polarity(5'b01010);
		push_random(PHASE_ITEMS);
		wait_drained();

		write_polarity(FIELD_W'($urandom));
		push_random(PHASE_ITEMS);
		push_cmd(OP_PERIOD, 5'd4, MODE_W'($urandom), 32'hFFFF_FFFF, $urandom);
		push_cmd(OP_MODE, 5'd4, MODE_BLINK, $urandom, $urandom);
		repeat (3)
			push_cmd(OP_TICK, FIELD_W'($urandom), MODE_W'($urandom), $urandom,
				32'hFFFF_FFFF);

		do @(posedge clk);
		while (cmds_accepted != cmds_pushed);
		waited = 0;
		while (expected_levels.size() != 0 && waited < 500) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
		while (expected_levels.size() != 0) begin
			report_mismatch("missing result beat, lit_mask", '0,
				expected_levels[0].lit_mask);
			void'(expected_levels.pop_front());
		end

		$display("run covered %0d command beats, %0d result beats, %0d LED toggles",
			cmds_accepted, results_seen, toggle_count);
		$display("and %0d polarity writes, with %0d mismatches", polarity_writes,
			mismatch_count);
		if (mismatch_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
